// ----- rtl/window_level_pixel_map_top_assert.svh -----
// ----------------------------------------------------------------------------
// window level pixel map assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef WINDOW_LEVEL_PIXEL_MAP_TOP_ASSERT_SVH
`define WINDOW_LEVEL_PIXEL_MAP_TOP_ASSERT_SVH

// same-cycle implication
`define WLPM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("wlpm assertion failed");

// next-cycle implication
`define WLPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("wlpm assertion failed");

`endif

// ----- rtl/wlpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlpm_pkg
// types and constants shared by the window level pixel map pipeline
// ----------------------------------------------------------------------------
package wlpm_pkg;

	localparam int LEVEL_W = 16;
	localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'hFFFF;

	// quotient bits resolved per divider stage, and number of stages
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = LEVEL_W / DIV_STEPS;

	// configuration register indexes
	localparam logic CFG_WINDOW_LOW  = 1'b0;
	localparam logic CFG_WINDOW_HIGH = 1'b1;

	typedef struct packed {
		logic force_zero;
		logic force_full;
		logic frame_end;
	} pix_ctl_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] rem;
		logic [LEVEL_W-1:0] quo;
		logic [LEVEL_W-1:0] low;
		logic [LEVEL_W-1:0] den;
		pix_ctl_t           ctl;
	} div_word_t;

endpackage

// ----- rtl/wlpm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlpm channel interfaces
// valid/ready channels for raw pixels in and mapped levels out
// ----------------------------------------------------------------------------
interface wlpm_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_in;
	logic        frame_end;

	modport source (output valid, output pixel_in, output frame_end, input ready);
	modport sink (input valid, input pixel_in, input frame_end, output ready);
endinterface

interface wlpm_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] level_out;
	logic [7:0]  display_byte;
	logic        frame_end_out;

	modport source (output valid, output level_out, output display_byte,
		output frame_end_out, input ready);
	modport sink (input valid, input level_out, input display_byte,
		input frame_end_out, output ready);
endinterface

// ----- rtl/wlpm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlpm_front
// window classification and divider operand setup, one register stage
// ----------------------------------------------------------------------------
module wlpm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [wlpm_pkg::LEVEL_W-1:0]        pixel,
	input  logic [wlpm_pkg::LEVEL_W-1:0]        win_low,
	input  logic [wlpm_pkg::LEVEL_W-1:0]        win_high,
	input  logic                                frame_end,
	output logic                                out_valid,
	input  logic                                out_ready,
	output wlpm_pkg::div_word_t                 out_word
);

	logic                         valid_s1;
	wlpm_pkg::div_word_t          word_s1;
	wlpm_pkg::div_word_t          word_d;
	logic [wlpm_pkg::LEVEL_W-1:0] offset;
	logic [wlpm_pkg::LEVEL_W-1:0] span;
	logic                         below;
	logic                         above;

	always_comb begin
		below  = pixel < win_low;
		above  = pixel > win_high;
		offset = pixel - win_low;
		span   = win_high - win_low;

		// offset*65535 = (offset-1)<<16 + (65536-offset) for nonzero offset
		word_d.rem = (offset != '0) ? offset - 16'd1 : '0;
		word_d.low = 16'd0 - offset;
		word_d.quo = '0;
		word_d.den = span;
		word_d.ctl.force_zero = below | (~above & (span == '0));
		word_d.ctl.force_full = ~below & above;
		word_d.ctl.frame_end  = frame_end;
	end

	assign in_ready = ~valid_s1 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= word_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule

// ----- rtl/wlpm_div_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlpm_div_stage
// one slice of the restoring divider, DIV_STEPS quotient bits per stage
// ----------------------------------------------------------------------------
module wlpm_div_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wlpm_pkg::div_word_t in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output wlpm_pkg::div_word_t out_word
);

	logic                valid_s1;
	wlpm_pkg::div_word_t word_s1;
	wlpm_pkg::div_word_t word_d;

	always_comb begin
		logic [wlpm_pkg::LEVEL_W:0]   trial;
		logic [wlpm_pkg::LEVEL_W-1:0] rem;
		logic [wlpm_pkg::LEVEL_W-1:0] quo;
		logic [wlpm_pkg::LEVEL_W-1:0] low;
		logic                         qbit;

		rem = in_word.rem;
		quo = in_word.quo;
		low = in_word.low;
		for (int i = 0; i < wlpm_pkg::DIV_STEPS; i++) begin
			trial = {rem, low[wlpm_pkg::LEVEL_W-1]};
			low   = {low[wlpm_pkg::LEVEL_W-2:0], 1'b0};
			qbit  = trial >= {1'b0, in_word.den};
			if (qbit) begin
				trial = trial - {1'b0, in_word.den};
			end
			rem = trial[wlpm_pkg::LEVEL_W-1:0];
			quo = {quo[wlpm_pkg::LEVEL_W-2:0], qbit};
		end
		word_d     = in_word;
		word_d.rem = rem;
		word_d.quo = quo;
		word_d.low = low;
	end

	assign in_ready = ~valid_s1 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= word_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule

// ----- rtl/wlpm_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlpm_out
// clamp selection, display byte and the output register
// ----------------------------------------------------------------------------
module wlpm_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  wlpm_pkg::div_word_t           in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wlpm_pkg::LEVEL_W-1:0]  level,
	output logic [7:0]                    display,
	output logic                          frame_end
);

	logic                         valid_s1;
	logic [wlpm_pkg::LEVEL_W-1:0] level_s1;
	logic [7:0]                   display_s1;
	logic                         frame_end_s1;
	logic [wlpm_pkg::LEVEL_W-1:0] level_d;
	logic [7:0]                   display_d;

	always_comb begin
		if (in_word.ctl.force_full) begin
			level_d = wlpm_pkg::FULL_SCALE;
		end else if (in_word.ctl.force_zero) begin
			level_d = '0;
		end else begin
			level_d = in_word.quo;
		end
		// level/257 with level = 256a + b is a, less one when b < a
		display_d = level_d[15:8] - {7'd0, (level_d[7:0] < level_d[15:8])};
	end

	assign in_ready = ~valid_s1 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1     <= level_d;
			display_s1   <= display_d;
			frame_end_s1 <= in_word.ctl.frame_end;
		end
	end

	assign out_valid = valid_s1;
	assign level     = level_s1;
	assign display   = display_s1;
	assign frame_end = frame_end_s1;

endmodule

// ----- rtl/window_level_pixel_map_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_level_pixel_map_top
// window/level mapping of 16-bit grey pixels to a stretched level and a byte
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns one
// result per pixel, in order. A pixel below window_low gives level 0, above
// window_high gives 65535, and inside the window gives floor((p - low) *
// 65535 / (high - low)); an empty window maps a pixel equal to both levels
// to 0. display_byte is level / 257. The registers are classification, four
// divider stages each resolving four of sixteen quotient bits, and output.
// Each stage has its own valid bit and hands data on when the next stage is
// empty or moving, so bubbles fill and a stalled output only holds back what
// sits behind it. Window registers are written through cfg_we/cfg_index/
// cfg_data and should only change while no transaction is in flight.
// PIXEL_BITS masks the pixel and both window levels to their low bits.
// ----------------------------------------------------------------------------
`include "window_level_pixel_map_top_assert.svh"

module window_level_pixel_map_top #(
	parameter int PIXEL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	wlpm_in_if.sink     in_ch,
	wlpm_out_if.source  out_ch
);

	// mask for the active pixel bits
	localparam logic [wlpm_pkg::LEVEL_W-1:0] PIX_MASK =
		wlpm_pkg::LEVEL_W'((32'd1 << PIXEL_BITS) - 32'd1);

	logic [wlpm_pkg::LEVEL_W-1:0] window_low_q;
	logic [wlpm_pkg::LEVEL_W-1:0] window_high_q;

	// stage 0 is the front end output, stages 1..DIV_STAGES the divider slices
	wlpm_pkg::div_word_t stg_word  [wlpm_pkg::DIV_STAGES+1];
	logic                stg_valid [wlpm_pkg::DIV_STAGES+1];
	logic                stg_ready [wlpm_pkg::DIV_STAGES+1];

	// configuration write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q  <= '0;
			window_high_q <= wlpm_pkg::FULL_SCALE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wlpm_pkg::CFG_WINDOW_LOW:  window_low_q  <= cfg_data;
				wlpm_pkg::CFG_WINDOW_HIGH: window_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify pixel against the window, set up dividend and divisor
	wlpm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.pixel     (in_ch.pixel_in & PIX_MASK),
		.win_low   (window_low_q & PIX_MASK),
		.win_high  (window_high_q & PIX_MASK),
		.frame_end (in_ch.frame_end),
		.out_valid (stg_valid[0]),
		.out_ready (stg_ready[0]),
		.out_word  (stg_word[0])
	);

	// pipelined restoring divider
	for (genvar g = 0; g < wlpm_pkg::DIV_STAGES; g++) begin : g_div
		wlpm_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[g]),
			.in_ready  (stg_ready[g]),
			.in_word   (stg_word[g]),
			.out_valid (stg_valid[g+1]),
			.out_ready (stg_ready[g+1]),
			.out_word  (stg_word[g+1])
		);
	end

	// clamp, display byte, output register
	wlpm_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stg_valid[wlpm_pkg::DIV_STAGES]),
		.in_ready  (stg_ready[wlpm_pkg::DIV_STAGES]),
		.in_word   (stg_word[wlpm_pkg::DIV_STAGES]),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.level     (out_ch.level_out),
		.display   (out_ch.display_byte),
		.frame_end (out_ch.frame_end_out)
	);

	// an accepted transaction lands in the first stage
	`WLPM_ASSERT_NEXT(a_in_to_s1, clk, arst_n, in_ch.valid && in_ch.ready, stg_valid[0])

	// an empty first stage never blocks input
	`WLPM_ASSERT_NOW(a_s1_empty_ready, clk, arst_n, !stg_valid[0], in_ch.ready)

	// display byte is the floor of level over 257
	`WLPM_ASSERT_NOW(a_disp_floor, clk, arst_n, out_ch.valid,
		(17'(out_ch.display_byte) * 17'd257 <= 17'(out_ch.level_out)) &&
		(17'(out_ch.level_out) - 17'(out_ch.display_byte) * 17'd257 < 17'd257))

	// full scale level always shows as full byte
	`WLPM_ASSERT_NOW(a_full_byte, clk, arst_n,
		out_ch.valid && (out_ch.level_out == wlpm_pkg::FULL_SCALE),
		out_ch.display_byte == 8'hFF)

endmodule
